// ===== hw/rtl/sbg_pkg.sv =====
// Package for the spatial bucket grid.
// Holds the grid geometry and the operation and status codes. It depends on nothing.
package sbg_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_INSERT   = 2'd1,
        OP_READ_XY  = 2'd2,
        OP_READ_IDX = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_CLEARED = 2'd2,
        ST_UNUSED  = 2'd3
    } t_status;

    localparam int GRID_SIDE        = 64;
    localparam int SLOTS_PER_BUCKET = 16;
    localparam int CELL_SHIFT       = 10;

endpackage

// ===== hw/rtl/sbg_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing.
module sbg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/spatial_bucket_grid_with_overflow_top.sv =====
// Spatial bucket grid with overflow chaining. The receiver cannot stall: every result
// is shown for one cycle on o_strobe. A clear writes every slot in turn through the
// single write port of the slot memory; the same clearing pass runs after reset, with
// busy high. A read fetches the bucket header in S_LOAD/S_LOADW, then passes S_RD_A/S_RD_B
// per slot. An insert passes S_LOAD/S_LOADW per chain bucket visited, S_INS_A/S_INS_B per
// slot tested and S_SCAN_A/S_SCAN_B per overflow bucket scanned when a new link is needed.
module spatial_bucket_grid_with_overflow_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sbg_pkg::t_op      i_operation,
    input  logic [15:0]       i_x_coord,
    input  logic [15:0]       i_y_coord,
    input  logic [31:0]       i_value,
    input  logic [12:0]       i_bucket_index,
    output logic              o_strobe,
    output sbg_pkg::t_status  o_status,
    output logic [12:0]       o_bucket_at,
    output logic [3:0]        o_slot_number,
    output logic [31:0]       o_slot_value,
    output logic [4:0]        o_fill_count,
    output logic [12:0]       o_next_link,
    output logic              o_last
);
    import sbg_pkg::*;

    localparam int PRIM = GRID_SIDE * GRID_SIDE;
    localparam int NB   = 2 * PRIM;
    localparam int BW   = $clog2(NB);
    localparam int GW   = $clog2(GRID_SIDE);
    localparam int SW   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int CW   = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int TOT  = NB * SLOTS_PER_BUCKET;
    localparam int AW   = $clog2(TOT);
    localparam int CLW  = $clog2(TOT + 1);
    localparam int STW  = $clog2(NB + 2);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_LOAD, S_LOADW, S_SCAN_A, S_SCAN_B,
        S_INS_A, S_INS_B, S_RD_A, S_RD_B
    } t_state;

    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic [31:0]            r_val, n_val;
    logic [BW-1:0]          r_b, n_b;
    logic [BW-1:0]          r_f, n_f;
    logic [AW-1:0]          r_base, n_base;
    logic [SW-1:0]          r_slot, n_slot;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [BW-1:0]          r_lnk, n_lnk;
    logic [STW-1:0]         r_steps, n_steps;
    logic                   r_runaway, n_runaway;
    logic [CLW-1:0]         r_clr, n_clr;
    logic                   r_emit_clr, n_emit_clr;
    logic                   r_strobe, n_strobe;
    t_status                r_status, n_status;
    logic [12:0]            r_bucket_at, n_bucket_at;
    logic [3:0]             r_slot_number, n_slot_number;
    logic [31:0]            r_slot_value, n_slot_value;
    logic [4:0]             r_fill_count, n_fill_count;
    logic [12:0]            r_next_link, n_next_link;
    logic                   r_last, n_last;

    logic                   slot_we, cnt_we, lnk_we;
    logic [AW-1:0]          slot_waddr, slot_raddr;
    logic [31:0]            slot_wdata, slot_rd;
    logic [BW-1:0]          cnt_waddr, cnt_raddr, lnk_waddr;
    logic [CW-1:0]          cnt_wdata, cnt_rd;
    logic [BW-1:0]          lnk_wdata, lnk_rd;

    sbg_ram #(.WIDTH(32), .DEPTH(TOT)) u_slots (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rd)
    );
    sbg_ram #(.WIDTH(CW), .DEPTH(NB)) u_counts (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(cnt_raddr), .o_rdata(cnt_rd)
    );
    sbg_ram #(.WIDTH(BW), .DEPTH(NB)) u_links (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(lnk_waddr), .i_wdata(lnk_wdata),
        .i_raddr(r_b), .o_rdata(lnk_rd)
    );

    assign slot_raddr = r_base + AW'(r_slot);
    assign cnt_raddr  = (r_state == S_SCAN_A) ? r_f : r_b;
    assign busy       = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;      n_op = r_op;          n_val = r_val;
        n_b = r_b;              n_f = r_f;            n_base = r_base;
        n_slot = r_slot;        n_cnt = r_cnt;        n_lnk = r_lnk;
        n_steps = r_steps;      n_runaway = r_runaway;
        n_clr = r_clr;          n_emit_clr = r_emit_clr;
        n_strobe = 1'b0;        n_status = r_status;  n_bucket_at = r_bucket_at;
        n_slot_number = r_slot_number;  n_slot_value = r_slot_value;
        n_fill_count = r_fill_count;    n_next_link = r_next_link;
        n_last = r_last;
        slot_we = 1'b0;  slot_waddr = r_clr[AW-1:0];  slot_wdata = '0;
        cnt_we = 1'b0;   cnt_waddr = r_clr[BW-1:0];   cnt_wdata = '0;
        lnk_we = 1'b0;   lnk_waddr = r_clr[BW-1:0];   lnk_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = i_operation;
                    n_val = i_value;
                    n_steps = '0;
                    n_runaway = 1'b0;
                    if (i_operation == OP_CLEAR) begin
                        n_clr = '0;
                        n_emit_clr = 1'b1;
                        n_state = S_CLR;
                    end else if (i_operation == OP_READ_IDX) begin
                        n_b = BW'(i_bucket_index);
                        n_state = S_LOAD;
                    end else begin
                        n_b = BW'({GW'(i_y_coord >> CELL_SHIFT),
                                   GW'(i_x_coord >> CELL_SHIFT)});
                        n_state = S_LOAD;
                    end
                end
            end
            S_CLR: begin
                slot_we = 1'b1;
                if (r_clr < CLW'(NB)) begin
                    cnt_we = 1'b1;
                    lnk_we = 1'b1;
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == CLW'(TOT - 1)) begin
                    n_state = S_IDLE;
                    if (r_emit_clr) begin
                        n_strobe = 1'b1;
                        n_status = ST_CLEARED;
                        n_bucket_at = '0;
                        n_slot_number = '0;
                        n_slot_value = '0;
                        n_fill_count = '0;
                        n_next_link = '0;
                        n_last = 1'b1;
                    end
                end
            end
            S_LOAD: begin
                n_base = AW'(r_b * SLOTS_PER_BUCKET);
                n_state = S_LOADW;
            end
            S_LOADW: begin
                n_cnt = cnt_rd;
                n_lnk = lnk_rd;
                n_slot = '0;
                if (r_runaway) begin
                    n_strobe = 1'b1;
                    n_status = ST_FULL;
                    n_bucket_at = 13'(r_b);
                    n_slot_number = '0;
                    n_slot_value = '0;
                    n_fill_count = 5'(cnt_rd);
                    n_next_link = 13'(lnk_rd);
                    n_last = 1'b1;
                    n_state = S_IDLE;
                end else if (r_op != OP_INSERT) begin
                    n_state = S_RD_A;
                end else if (cnt_rd >= CW'(SLOTS_PER_BUCKET)) begin
                    if (lnk_rd == '0) begin
                        n_f = BW'(PRIM);
                        n_state = S_SCAN_A;
                    end else begin
                        n_b = lnk_rd;
                        n_steps = r_steps + 1'b1;
                        n_runaway = (r_steps + 1'b1) > STW'(NB);
                        n_state = S_LOAD;
                    end
                end else begin
                    n_state = S_INS_A;
                end
            end
            S_SCAN_A: begin
                n_state = S_SCAN_B;
            end
            S_SCAN_B: begin
                if (cnt_rd == '0) begin
                    lnk_we = 1'b1;
                    lnk_waddr = r_b;
                    lnk_wdata = r_f;
                    n_b = r_f;
                    n_steps = r_steps + 1'b1;
                    n_runaway = (r_steps + 1'b1) > STW'(NB);
                    n_state = S_LOAD;
                end else if (r_f == BW'(NB - 1)) begin
                    n_strobe = 1'b1;
                    n_status = ST_FULL;
                    n_bucket_at = 13'(r_b);
                    n_slot_number = '0;
                    n_slot_value = '0;
                    n_fill_count = 5'(r_cnt);
                    n_next_link = 13'(r_lnk);
                    n_last = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_f = r_f + 1'b1;
                    n_state = S_SCAN_A;
                end
            end
            S_INS_A: begin
                n_state = S_INS_B;
            end
            S_INS_B: begin
                if (slot_rd == '0 || r_slot == SW'(SLOTS_PER_BUCKET - 1)) begin
                    if (slot_rd == '0) begin
                        slot_we = 1'b1;
                        slot_waddr = slot_raddr;
                        slot_wdata = r_val;
                        n_slot_number = 4'(r_slot);
                    end else begin
                        n_slot_number = '0;
                    end
                    cnt_we = 1'b1;
                    cnt_waddr = r_b;
                    cnt_wdata = r_cnt + 1'b1;
                    n_strobe = 1'b1;
                    n_status = ST_OK;
                    n_bucket_at = 13'(r_b);
                    n_slot_value = r_val;
                    n_fill_count = 5'(r_cnt + 1'b1);
                    n_next_link = 13'(r_lnk);
                    n_last = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_slot = r_slot + 1'b1;
                    n_state = S_INS_A;
                end
            end
            S_RD_A: begin
                n_state = S_RD_B;
            end
            S_RD_B: begin
                n_strobe = 1'b1;
                n_status = ST_OK;
                n_bucket_at = 13'(r_b);
                n_slot_number = 4'(r_slot);
                n_slot_value = slot_rd;
                n_fill_count = 5'(r_cnt);
                n_next_link = 13'(r_lnk);
                n_last = (r_slot == SW'(SLOTS_PER_BUCKET - 1));
                if (r_slot == SW'(SLOTS_PER_BUCKET - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_slot = r_slot + 1'b1;
                    n_state = S_RD_A;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_emit_clr <= 1'b0;
            r_strobe <= 1'b0;
            r_runaway <= 1'b0;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_emit_clr <= n_emit_clr;
            r_strobe <= n_strobe;
            r_runaway <= n_runaway;
            r_steps <= n_steps;
        end
        r_op <= n_op;            r_val <= n_val;        r_b <= n_b;
        r_f <= n_f;              r_base <= n_base;      r_slot <= n_slot;
        r_cnt <= n_cnt;          r_lnk <= n_lnk;        r_status <= n_status;
        r_bucket_at <= n_bucket_at;      r_slot_number <= n_slot_number;
        r_slot_value <= n_slot_value;    r_fill_count <= n_fill_count;
        r_next_link <= n_next_link;      r_last <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_bucket_at   = r_bucket_at;
    assign o_slot_number = r_slot_number;
    assign o_slot_value  = r_slot_value;
    assign o_fill_count  = r_fill_count;
    assign o_next_link   = r_next_link;
    assign o_last        = r_last;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not raise busy");
    a_read_cadence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> ##2 o_strobe) else $error("read result missing");
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_CLEARED || o_status == ST_FULL)) |-> o_last)
        else $error("single result not marked last");
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (o_slot_value == '0))
        else $error("dropped value reported");
endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the spatial bucket grid with overflow chaining.
// Depends on sbg_pkg and spatial_bucket_grid_with_overflow_top; runs a directed
// stimulus table, then random inserts and reads aimed at a few hot buckets.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbg_pkg::*;

    localparam int PRIMARY = 4096;
    localparam int BUCKETS = 8192;
    localparam int SLOTS   = 16;
    localparam int N_RANDOM = 210;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        t_status     status;
        logic [12:0] bucket;
        logic [3:0]  slot;
        logic [31:0] value;
        logic [4:0]  fill;
        logic [12:0] link;
        logic        last;
    } t_grid_result;

    typedef struct {
        t_op         op;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] value;
        logic [12:0] index;
        bit          typed;
        t_status     st;
        logic [31:0] val;
        logic [4:0]  fill;
        logic [12:0] link;
    } t_stim_row;

    logic        i_clk = 0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_op         i_operation;
    logic [15:0] i_x_coord;
    logic [15:0] i_y_coord;
    logic [31:0] i_value;
    logic [12:0] i_bucket_index;
    logic        o_strobe;
    t_status     o_status;
    logic [12:0] o_bucket_at;
    logic [3:0]  o_slot_number;
    logic [31:0] o_slot_value;
    logic [4:0]  o_fill_count;
    logic [12:0] o_next_link;
    logic        o_last;

    logic [31:0] slot_mem[int];
    logic [4:0]  fill_mem[int];
    logic [12:0] link_mem[int];
    t_grid_result pending_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int inserts_done = 0;
    int reads_done = 0;
    longint cycles = 0;

    spatial_bucket_grid_with_overflow_top i_dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic logic [31:0] slot_at(int b, int s);
        return slot_mem.exists(b * SLOTS + s) ? slot_mem[b * SLOTS + s] : 32'd0;
    endfunction

    function automatic logic [4:0] fill_at(int b);
        return fill_mem.exists(b) ? fill_mem[b] : 5'd0;
    endfunction

    function automatic logic [12:0] link_at(int b);
        return link_mem.exists(b) ? link_mem[b] : 13'd0;
    endfunction

    function automatic t_grid_result make_result(t_status st, int b, int s, logic [31:0] v,
                                                 logic [4:0] f, logic [12:0] l, bit last);
        t_grid_result r;
        r.status = st;
        r.bucket = b[12:0];
        r.slot   = s[3:0];
        r.value  = v;
        r.fill   = f;
        r.link   = l;
        r.last   = last;
        return r;
    endfunction

    function automatic void insert_value(int b, logic [31:0] v);
        int steps;
        int s;
        int f;
        steps = 0;
        while (fill_at(b) >= SLOTS) begin
            if (link_at(b) == 0) begin
                f = 0;
                for (int i = PRIMARY; i < BUCKETS; i++) begin
                    if (fill_at(i) == 0) begin
                        f = i;
                        break;
                    end
                end
                if (f == 0) begin
                    pending_results.push_back(make_result(ST_FULL, b, 0, 32'd0, fill_at(b),
                                                          link_at(b), 1'b1));
                    return;
                end
                link_mem[b] = f[12:0];
            end
            b = int'(link_at(b));
            steps++;
            if (steps > BUCKETS) begin
                pending_results.push_back(make_result(ST_FULL, b, 0, 32'd0, fill_at(b),
                                                      link_at(b), 1'b1));
                return;
            end
        end
        for (s = 0; s < SLOTS; s++) begin
            if (slot_at(b, s) == 0) begin
                slot_mem[b * SLOTS + s] = v;
                break;
            end
        end
        if (s >= SLOTS) s = 0;
        fill_mem[b] = fill_at(b) + 5'd1;
        pending_results.push_back(make_result(ST_OK, b, s, v, fill_at(b), link_at(b), 1'b1));
    endfunction

    function automatic void predict_item(t_stim_row row);
        int b;
        b = (row.op == OP_READ_IDX) ? int'(row.index) : int'({row.y[15:10], row.x[15:10]});
        case (row.op)
            OP_CLEAR: begin
                slot_mem.delete();
                fill_mem.delete();
                link_mem.delete();
                pending_results.push_back(make_result(ST_CLEARED, 0, 0, 32'd0, 5'd0, 13'd0,
                                                      1'b1));
            end
            OP_INSERT: begin
                inserts_done++;
                insert_value(b, row.value);
            end
            default: begin
                reads_done++;
                for (int s = 0; s < SLOTS; s++)
                    pending_results.push_back(make_result(ST_OK, b, s, slot_at(b, s),
                                                          fill_at(b), link_at(b), s == SLOTS - 1));
            end
        endcase
        if (row.typed) begin
            for (int k = pending_results.size() - 1; k >= 0; k--) begin
                if (k < pending_results.size() - 1 && pending_results[k].last) break;
                pending_results[k].status = row.st;
                pending_results[k].value  = row.val;
                pending_results[k].fill   = row.fill;
                pending_results[k].link   = row.link;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_grid_result e;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at bucket %0d", o_bucket_at);
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status || o_bucket_at !== e.bucket ||
                    o_slot_number !== e.slot || o_slot_value !== e.value ||
                    o_fill_count !== e.fill || o_next_link !== e.link || o_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: exp st=%0d b=%0d s=%0d v=%h f=%0d n=%0d l=%0d",
                                 e.status, e.bucket, e.slot, e.value, e.fill, e.link, e.last);
                        $display("          got st=%0d b=%0d s=%0d v=%h f=%0d n=%0d l=%0d",
                                 o_status, o_bucket_at, o_slot_number, o_slot_value,
                                 o_fill_count, o_next_link, o_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic issue(t_stim_row row, int gap_pct);
        i_operation    <= row.op;
        i_x_coord      <= row.x;
        i_y_coord      <= row.y;
        i_value        <= row.value;
        i_bucket_index <= row.index;
        start          <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_item(row);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(20, 1)) @(posedge i_clk);
        end
    endtask

    function automatic t_stim_row random_row();
        t_stim_row r;
        int pick;
        int hot;
        r = '{OP_INSERT, 16'h0, 16'h0, 32'h0, 13'h0, 1'b0, ST_OK, 32'h0, 5'h0, 13'h0};
        r.x = 16'($urandom());
        r.y = 16'($urandom());
        r.value = ($urandom_range(99) < 5) ? 32'd0 : $urandom();
        r.index = 13'($urandom());
        pick = $urandom_range(99);
        hot = $urandom_range(2);
        if (pick < 70) begin
            if ($urandom_range(99) < 75) begin
                r.x[15:10] = 6'(hot * 21);
                r.y[15:10] = 6'(hot * 17);
            end
        end else if (pick < 85) begin
            r.op = OP_READ_XY;
            r.x[15:10] = 6'(hot * 21);
            r.y[15:10] = 6'(hot * 17);
        end else begin
            r.op = OP_READ_IDX;
            if ($urandom_range(1)) r.index = 13'(PRIMARY + $urandom_range(12));
        end
        return r;
    endfunction

    function automatic t_stim_row random_row_at_corner(int k);
        t_stim_row r;
        r = '{OP_INSERT, 16'h0, 16'h0, 32'h0, 13'h0, 1'b0, ST_OK, 32'h0, 5'h0, 13'h0};
        r.x = {6'd63, 10'($urandom())};
        r.y = {6'd0, 10'($urandom())};
        r.value = $urandom() | 32'(k + 1);
        return r;
    endfunction

    t_stim_row directed[] = '{
        '{OP_READ_IDX, 16'h0000, 16'h0000, 32'h0, 13'd0,    1, ST_OK, 32'h0, 5'd0, 13'd0},
        '{OP_READ_IDX, 16'h0000, 16'h0000, 32'h0, 13'd8191, 1, ST_OK, 32'h0, 5'd0, 13'd0},
        '{OP_INSERT, 16'h0000, 16'h0000, 32'hFFFFFFFF, 13'd0, 1, ST_OK, 32'hFFFFFFFF, 5'd1, 13'd0},
        '{OP_INSERT, 16'hFFFF, 16'hFFFF, 32'h00000001, 13'd0, 1, ST_OK, 32'h1, 5'd1, 13'd0},
        '{OP_INSERT, 16'h03FF, 16'h03FF, 32'h0, 13'd0,       1, ST_OK, 32'h0, 5'd2, 13'd0},
        '{OP_INSERT, 16'h0000, 16'h0000, 32'hA5A5A5A5, 13'd0, 0, ST_OK, 32'h0, 5'd0, 13'd0},
        '{OP_INSERT, 16'hFC00, 16'h0000, 32'h5A5A5A5A, 13'd0, 0, ST_OK, 32'h0, 5'd0, 13'd0},
        '{OP_INSERT, 16'h0000, 16'hFC00, 32'h12345678, 13'd0, 0, ST_OK, 32'h0, 5'd0, 13'd0},
        '{OP_READ_XY, 16'h0123, 16'h0321, 32'h0, 13'd0,      0, ST_OK, 32'h0, 5'd0, 13'd0},
        '{OP_READ_XY, 16'hFFFF, 16'hFFFF, 32'h0, 13'd0,      0, ST_OK, 32'h0, 5'd0, 13'd0},
        '{OP_READ_IDX, 16'h0000, 16'h0000, 32'h0, 13'd63,    0, ST_OK, 32'h0, 5'd0, 13'd0},
        '{OP_READ_IDX, 16'h0000, 16'h0000, 32'h0, 13'd4096,  1, ST_OK, 32'h0, 5'd0, 13'd0},
        '{OP_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 13'd8191, 1, ST_CLEARED, 32'h0, 5'd0, 13'd0},
        '{OP_READ_IDX, 16'h0000, 16'h0000, 32'h0, 13'd0,     1, ST_OK, 32'h0, 5'd0, 13'd0},
        '{OP_READ_IDX, 16'h0000, 16'h0000, 32'h0, 13'd4095,  1, ST_OK, 32'h0, 5'd0, 13'd0}
    };

    initial begin
        int gap_pct;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_operation    <= OP_CLEAR;
        i_x_coord      <= '0;
        i_y_coord      <= '0;
        i_value        <= '0;
        i_bucket_index <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k]) issue(directed[k], 0);
        // Seventeen inserts into one bucket force the first overflow link.
        for (int k = 0; k < 17; k++) issue(random_row_at_corner(k), 0);
        for (int phase = 0; phase < 4; phase++) begin
            gap_pct = (phase == 1) ? 84 : (phase == 3) ? 8 : 0;
            for (int k = 0; k < N_RANDOM / 4; k++) issue(random_row(), gap_pct);
            start <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
        end
        repeat (300) @(posedge i_clk);
        $display("Covered %0d inserts and %0d reads with %0d results checked,", inserts_done,
                 reads_done, results_seen);
        $display("including chained overflow buckets, clear and idle sender phases.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
